>>> rtl/ebl_pkg.sv
package ebl_pkg;

  // fixed field widths
  localparam int ARMS_W    = 4;
  localparam int DRAW_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int RWD_W     = 24;
  localparam int OUT_ARM_W = 3;
  localparam int OUT_VAL_W = 24;
  localparam int CNT_W     = 4;
  localparam int CFG_AW    = 4;
  localparam int PDATA_W   = 32;

  localparam int ARMS_MAX   = 2 ** ARMS_W - 1;
  localparam int INIT_VALUE = 25600;
  localparam int ROUND_HALF = 32768;

  localparam logic [OUT_VAL_W-1:0] OUT_MAX = {1'b0, {(OUT_VAL_W-1){1'b1}}};
  localparam logic [OUT_VAL_W-1:0] OUT_MIN = {1'b1, {(OUT_VAL_W-1){1'b0}}};

  localparam logic [ARMS_W-1:0] RST_ARMS = 4'd5;
  localparam logic [DRAW_W-1:0] RST_EPS  = 16'd6554;
  localparam logic [FRAC_W-1:0] RST_LR   = 16'd6554;
  localparam logic [RWD_W-1:0]  RST_BIAS = 24'd0;

  typedef enum logic {
    ACT_DECIDE = 1'b0,
    ACT_UPDATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    REG_ARMS = 2'd0,
    REG_EPS  = 2'd1,
    REG_LR   = 2'd2,
    REG_BIAS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [ARMS_W-1:0]       arms;
    logic [DRAW_W-1:0]       eps;
    logic [FRAC_W-1:0]       lr;
    logic signed [RWD_W-1:0] bias;
  } cfg_t;

endpackage

>>> rtl/ebl_if.sv
interface ebl_in_if import ebl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [DRAW_W-1:0]       explore_draw;
  logic [DRAW_W-1:0]       arm_draw;
  logic signed [RWD_W-1:0] reward;

  modport source (
    output valid, action, explore_draw, arm_draw, reward,
    input  ready
  );
  modport sink (
    input  valid, action, explore_draw, arm_draw, reward,
    output ready
  );
endinterface

interface ebl_out_if import ebl_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OUT_ARM_W-1:0]        chosen_arm;
  logic                        explored;
  logic signed [OUT_VAL_W-1:0] updated_value;

  modport source (
    output valid, chosen_arm, explored, updated_value,
    input  ready
  );
  modport sink (
    input  valid, chosen_arm, explored, updated_value,
    output ready
  );
endinterface

>>> rtl/epsilon_greedy_bandit_learner_core.sv
// channel   dir  handshake     payload
// in_i      in   valid/ready   action, explore_draw, arm_draw, reward
// out_o     out  valid/ready   chosen_arm, explored, updated_value
// apb       in   psel/penable  paddr (reg * 4), pwdata, prdata, pready
//
// one request at a time through a single shared adder under a small sequencer
// explore decide: 16 restoring-modulo steps on the adder
// greedy decide: one estimate read and compare per arm
// update: 16 shift-add multiply steps on the adder
// reset sets every estimate to INIT_VALUE (25600) at once via per-entry valid bits
// input is taken again while a finished result still waits in the output register
module epsilon_greedy_bandit_learner_core import ebl_pkg::*; #(
  parameter int NUM_ARMS   = 8,
  parameter int VALUE_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ebl_in_if.sink             in_i,
  ebl_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int RW = (VALUE_BITS > RWD_W) ? VALUE_BITS : RWD_W;
  localparam int DW = RW + 2;
  localparam int PW = DW + FRAC_W + 1;
  localparam int EW = (VALUE_BITS > OUT_VAL_W) ? VALUE_BITS : OUT_VAL_W;
  localparam int CW = (AW > ARMS_W) ? AW : ARMS_W;
  localparam logic [ARMS_W-1:0] ARMS_CAP =
    ARMS_W'((NUM_ARMS > ARMS_MAX) ? ARMS_MAX : NUM_ARMS);
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_EXPL     = 12'b0000_0000_0010,
    S_DIV      = 12'b0000_0000_0100,
    S_FETCH    = 12'b0000_0000_1000,
    S_LOAD     = 12'b0000_0001_0000,
    S_SCAN_RD  = 12'b0000_0010_0000,
    S_SCAN_CMP = 12'b0000_0100_0000,
    S_U_SUM    = 12'b0000_1000_0000,
    S_U_DIFF   = 12'b0001_0000_0000,
    S_MUL      = 12'b0010_0000_0000,
    S_U_FIN    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;
  logic   act_q, act_d;
  logic   expl_q, expl_d;
  logic [AW-1:0] arm_q, arm_d;
  logic [AW-1:0] last_arm_q, last_arm_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ARMS_W-1:0] rem_q, rem_d;
  logic [DRAW_W-1:0] xdraw_q, xdraw_d;
  logic [DRAW_W-1:0] draw_q, draw_d;
  logic [FRAC_W-1:0] mplier_q, mplier_d;
  logic signed [RWD_W-1:0] rwd_q, rwd_d;
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic signed [PW-1:0] acc_q, acc_d;
  logic signed [PW-1:0] mcand_q, mcand_d;

  logic out_vld_q, out_vld_d;
  logic [OUT_ARM_W-1:0] out_arm_q, out_arm_d;
  logic out_expl_q, out_expl_d;
  logic [OUT_VAL_W-1:0] out_val_q, out_val_d;

  logic [ARMS_W-1:0] arms_eff;
  logic [ARMS_W:0] trial;
  alu_op_e alu_op;
  logic signed [PW-1:0] alu_a, alu_b;
  logic [PW-1:0] alu_sum;
  logic alu_neg;
  logic fits;
  logic [VALUE_BITS-1:0] sat;
  logic signed [EW-1:0] val_ext;
  logic ofits;
  logic take;
  logic [AW-1:0] rd_addr;
  logic signed [VALUE_BITS-1:0] mem_rd;
  logic mem_we;

  ebl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ebl_alu #(.W(PW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  ebl_value_mem #(
    .NUM_ARMS   (NUM_ARMS),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (arm_q),
    .wr_data_i (sat)
  );

  assign arms_eff = (cfg.arms == '0) ? ARMS_W'(1) :
                    ((cfg.arms > ARMS_CAP) ? ARMS_CAP : cfg.arms);
  assign trial    = {rem_q, draw_q[DRAW_W-1]};
  assign alu_neg  = alu_sum[PW-1];
  assign rd_addr  = (state_q == S_SCAN_RD) ? scan_q : arm_q;
  assign mem_we   = (state_q == S_U_FIN);

  // saturate the updated estimate to the estimate width
  assign fits = (&alu_sum[PW-1:VALUE_BITS-1]) || !(|alu_sum[PW-1:VALUE_BITS-1]);
  assign sat  = fits ? alu_sum[VALUE_BITS-1:0] : (alu_sum[PW-1] ? VAL_MIN : VAL_MAX);

  // clamp the reported value to the output field
  assign val_ext = EW'(val_q);
  assign ofits   = (&val_ext[EW-1:OUT_VAL_W-1]) || !(|val_ext[EW-1:OUT_VAL_W-1]);

  assign take = (scan_q == '0) || alu_neg;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = acc_q;
    alu_b  = mcand_q;
    case (state_q)
      S_EXPL: begin
        alu_op = ALU_SUB;
        alu_a  = PW'(xdraw_q);
        alu_b  = PW'(cfg.eps);
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = PW'(trial);
        alu_b  = PW'(arms_eff);
      end
      S_SCAN_CMP: begin
        // best - candidate below zero means the candidate is larger
        alu_op = ALU_SUB;
        alu_a  = PW'(val_q);
        alu_b  = PW'(mem_rd);
      end
      S_U_SUM: begin
        alu_a = PW'(rwd_q);
        alu_b = PW'(cfg.bias);
      end
      S_U_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = PW'(mem_rd);
      end
      S_MUL: begin
        alu_a = acc_q;
        alu_b = mcand_q;
      end
      S_U_FIN: begin
        alu_a = PW'(val_q);
        alu_b = acc_q >>> FRAC_W;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    expl_d     = expl_q;
    arm_d      = arm_q;
    last_arm_d = last_arm_q;
    scan_d     = scan_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    xdraw_d    = xdraw_q;
    draw_d     = draw_q;
    mplier_d   = mplier_q;
    rwd_d      = rwd_q;
    val_d      = val_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_arm_d  = out_arm_q;
    out_expl_d = out_expl_q;
    out_val_d  = out_val_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          xdraw_d = in_i.explore_draw;
          draw_d  = in_i.arm_draw;
          rwd_d   = in_i.reward;
          if (in_i.action == ACT_UPDATE) begin
            arm_d   = last_arm_q;
            expl_d  = 1'b0;
            state_d = S_U_SUM;
          end else begin
            state_d = S_EXPL;
          end
        end
      end
      S_EXPL: begin
        if (alu_neg) begin
          expl_d  = 1'b1;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          expl_d  = 1'b0;
          scan_d  = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_DIV: begin
        // restoring modulo, one draw bit per step
        rem_d  = alu_neg ? trial[ARMS_W-1:0] : alu_sum[ARMS_W-1:0];
        draw_d = draw_q << 1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          arm_d   = AW'(rem_d);
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        val_d   = mem_rd;
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (take) begin
          val_d = mem_rd;
          arm_d = scan_q;
        end
        if (CW'(scan_q) == CW'(arms_eff) - CW'(1)) begin
          state_d = S_DONE;
        end else begin
          scan_d  = scan_q + AW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_U_SUM: begin
        acc_d   = alu_sum;
        state_d = S_U_DIFF;
      end
      S_U_DIFF: begin
        mcand_d  = alu_sum;
        val_d    = mem_rd;
        acc_d    = PW'(ROUND_HALF);
        mplier_d = cfg.lr;
        cnt_d    = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          acc_d = alu_sum;
        end
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = S_U_FIN;
        end
      end
      S_U_FIN: begin
        val_d   = sat;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_arm_d  = OUT_ARM_W'(arm_q);
          out_expl_d = expl_q;
          out_val_d  = ofits ? val_ext[OUT_VAL_W-1:0] :
                       (val_ext[EW-1] ? OUT_MIN : OUT_MAX);
          if (act_q == ACT_DECIDE) begin
            last_arm_d = arm_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_arm_q <= '0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
      scan_q     <= '0;
    end else begin
      state_q    <= state_d;
      last_arm_q <= last_arm_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
      scan_q     <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    expl_q     <= expl_d;
    arm_q      <= arm_d;
    rem_q      <= rem_d;
    xdraw_q    <= xdraw_d;
    draw_q     <= draw_d;
    mplier_q   <= mplier_d;
    rwd_q      <= rwd_d;
    val_q      <= val_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    out_arm_q  <= out_arm_d;
    out_expl_q <= out_expl_d;
    out_val_q  <= out_val_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.chosen_arm    = out_arm_q;
  assign out_o.explored      = out_expl_q;
  assign out_o.updated_value = out_val_q;

endmodule

>>> rtl/ebl_alu.sv
module ebl_alu import ebl_pkg::*; #(
  parameter int W = 42
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] sum_o
);

  // single adder, shared by compare, modulo, update sum and difference, multiply and final saturating add steps
  assign sum_o = (op_i == ALU_SUB) ? (a_i - b_i) : (a_i + b_i);

endmodule

>>> rtl/ebl_value_mem.sv
module ebl_value_mem import ebl_pkg::*; #(
  parameter int NUM_ARMS   = 8,
  parameter int VALUE_BITS = 24,
  parameter int AW         = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [VALUE_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [VALUE_BITS-1:0] wr_data_i
);

  logic [VALUE_BITS-1:0] mem_q [NUM_ARMS];
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [NUM_ARMS-1:0]   vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // entries never written read back as the reset estimate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : VALUE_BITS'(INIT_VALUE);

endmodule

>>> rtl/ebl_cfg_regs.sv
module ebl_cfg_regs import ebl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ARMS: cfg_d.arms = pwdata[ARMS_W-1:0];
        REG_EPS:  cfg_d.eps  = pwdata[DRAW_W-1:0];
        REG_LR:   cfg_d.lr   = pwdata[FRAC_W-1:0];
        REG_BIAS: cfg_d.bias = pwdata[RWD_W-1:0];
        default:  cfg_d      = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ARMS: prdata = PDATA_W'(cfg_q.arms);
      REG_EPS:  prdata = PDATA_W'(cfg_q.eps);
      REG_LR:   prdata = PDATA_W'(cfg_q.lr);
      REG_BIAS: prdata = {{(PDATA_W-RWD_W){cfg_q.bias[RWD_W-1]}}, cfg_q.bias};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arms <= RST_ARMS;
      cfg_q.eps  <= RST_EPS;
      cfg_q.lr   <= RST_LR;
      cfg_q.bias <= RST_BIAS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
